/* hdl/gmps_pkg.sv */
// ----------------------------------------------------------------------------
// gmps_pkg: shared types and constants for the grid minimum path sum block
// Widths, register indexes and the dimension clamp used by the cost chain.
// ----------------------------------------------------------------------------
`default_nettype none

package gmps_pkg;

  localparam int MaxDim  = 64;
  localparam int DimW    = $clog2(MaxDim);
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;
  localparam int CostW   = 8;
  localparam int SumW    = 15;

  localparam logic [CfgIdxW-1:0] RegRows = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCols = CfgIdxW'(1);

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef logic [SumW-1:0]  sum_t;
  typedef logic [CostW-1:0] cost_t;
  typedef logic [DimW-1:0]  dim_t;
  typedef logic [CfgW-1:0]  cfg_t;

  // per-cell control: advance the chain, and load the new column value here
  typedef struct packed {
    logic shift;
    logic take_new;
  } cell_ctrl_t;

  // register value to last index: 0 acts as 1, oversize clamps to MaxDim
  function automatic dim_t dim_last(cfg_t v);
    cfg_t t;
    if (v == '0) begin
      t = '0;
    end else if (32'(v) > MaxDim) begin
      t = CfgW'(MaxDim - 1);
    end else begin
      t = v - CfgW'(1);
    end
    return t[DimW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/gmps_in_if.sv */
// ----------------------------------------------------------------------------
// gmps_in_if: cell cost input channel
// Valid/ready channel carrying one grid cell cost per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmps_in_if import gmps_pkg::*; ();
  logic  valid;
  logic  ready;
  cost_t cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink   (input valid, input cell_cost, output ready);
endinterface

`default_nettype wire

/* hdl/gmps_out_if.sv */
// ----------------------------------------------------------------------------
// gmps_out_if: minimum sum result channel
// Valid/ready channel carrying one path sum per completed grid.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmps_out_if import gmps_pkg::*; ();
  logic valid;
  logic ready;
  sum_t min_sum;

  modport source (output valid, output min_sum, input ready);
  modport sink   (input valid, input min_sum, output ready);
endinterface

`default_nettype wire

/* hdl/grid_min_path_sum_top.sv */
// ----------------------------------------------------------------------------
// grid_min_path_sum_top: cheapest right/down path sum over a cost grid
// Row-by-row dynamic program over a chain of column cost cells.
// ----------------------------------------------------------------------------
// Cells arrive one per transfer in row-major order, one per clock cycle when
// both sides keep up. Each transfer shifts a 64-cell chain towards cell 0; the
// new best cost enters at cell cols-1, so cell 0 always holds the best cost of
// the same column in the row above. The add/min/saturate on cell 0, the left
// register and the cost is the only logic per cycle, so a cell is taken every
// cycle. The sum of the bottom-right cell is registered and shown in the cycle
// after its transfer; input stalls only when that last cell of a grid arrives
// while the previous sum is still not taken. A write to rows or cols restarts
// the grid; values of 0 act as 1 and values above 64 act as 64.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_min_path_sum_top import gmps_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgW-1:0]      cfg_data_i,
  gmps_in_if.sink             in_i,
  gmps_out_if.source          out_o
);

  cfg_t rows_q, cols_q;
  dim_t row_q, row_d, col_q, col_d;
  sum_t left_q;
  logic out_valid_q, out_valid_d;
  sum_t min_sum_q, min_sum_d;

  dim_t nr_last, nc_last;
  logic last_cell, in_xfer, cfg_hit;
  sum_t above, base, best;
  logic [SumW:0] sum_wide;

  sum_t       chain [MaxDim];
  cell_ctrl_t ctrl  [MaxDim];

  assign nr_last   = dim_last(rows_q);
  assign nc_last   = dim_last(cols_q);
  assign last_cell = (row_q == nr_last) && (col_q == nc_last);

  // only the grid's final cell needs a free output register
  assign in_i.ready = !(out_valid_q && !out_o.ready && last_cell);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == RegRows) || (cfg_idx_i == RegCols));

  assign above = chain[0];

  always_comb begin
    if (row_q == '0 && col_q == '0) begin
      base = '0;
    end else if (row_q == '0) begin
      base = left_q;
    end else if (col_q == '0) begin
      base = above;
    end else begin
      base = (above < left_q) ? above : left_q;
    end
    sum_wide = {1'b0, base} + (SumW+1)'(in_i.cell_cost);
    best     = (sum_wide > {1'b0, SumMax}) ? SumMax : sum_wide[SumW-1:0];
  end

  // cost chain
  for (genvar i = 0; i < MaxDim; i++) begin : g_cell
    sum_t chain_in;
    if (i == MaxDim - 1) begin : g_end
      assign chain_in = '0;
    end else begin : g_mid
      assign chain_in = chain[i+1];
    end
    assign ctrl[i].shift    = in_xfer;
    assign ctrl[i].take_new = (nc_last == DimW'(i));

    gmps_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .chain_d_i (chain_in),
      .new_d_i   (best),
      .q_o       (chain[i])
    );
  end

  // position counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end else if (in_xfer) begin
      if (last_cell) begin
        row_d = '0;
        col_d = '0;
      end else if (col_q == nc_last) begin
        col_d = '0;
        row_d = row_q + DimW'(1);
      end else begin
        col_d = col_q + DimW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    min_sum_d   = min_sum_q;
    if (in_xfer && last_cell) begin
      out_valid_d = 1'b1;
      min_sum_d   = best;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= CfgW'(5);
      cols_q      <= CfgW'(5);
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegRows) begin
        rows_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == RegCols) begin
        cols_q <= cfg_data_i;
      end
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      left_q <= best;
    end
    min_sum_q <= min_sum_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.min_sum = min_sum_q;

  // checks
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= nr_last) && (col_q <= nc_last))
    else $error("grid position beyond configured size");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(in_xfer && last_cell))
    else $error("result without final cell transfer");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_valid_q && last_cell))
    else $error("input stalled without a pending result");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_cell && !cfg_hit) |=> (row_q == '0 && col_q == '0))
    else $error("grid did not restart after final cell");

endmodule

`default_nettype wire

/* hdl/gmps_cell.sv */
// ----------------------------------------------------------------------------
// gmps_cell: one stage of the row cost chain
// Holds the best cost of one column; takes its neighbour's value on a shift,
// or the freshly computed cost when it is the row's entry point.
// ----------------------------------------------------------------------------
`default_nettype none

module gmps_cell import gmps_pkg::*; (
  input  wire        clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire sum_t  chain_d_i,
  input  wire sum_t  new_d_i,
  output sum_t       q_o
);

  sum_t cost_q;
  sum_t cost_d;

  assign cost_d = ctrl_i.take_new ? new_d_i : chain_d_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      cost_q <= cost_d;
    end
  end

  assign q_o = cost_q;

endmodule

`default_nettype wire

/* tb/grid_min_path_sum_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_min_path_sum_top_tb: self-checking bench for the grid min path sum block
// Streams cost grids in row-major order over the cell channel. A row-buffer
// DP of its own predicts each bottom-right sum, and the bench checks every sum
// transfer in order. Covers reset, zero and clamped dimensions, grid restart
// on register writes, spare register indexes, back-pressure that fills the
// block, sender pauses and random idle on both channels.
// ----------------------------------------------------------------------------
module grid_min_path_sum_top_tb;
  import gmps_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int RandomCells  = 520;
  localparam cfg_t DimReset   = CfgW'(5);

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] RegSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareHi = CfgIdxW'(3);

  typedef enum int {CostAny, CostMax, CostZero, CostTie, CostLow} cost_mode_e;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  cfg_t               cfg_data_i;

  gmps_in_if  cell_if ();
  gmps_out_if sum_if ();

  grid_min_path_sum_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cell_if),
    .out_o      (sum_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  cfg_t        rows_reg  = DimReset;
  cfg_t        cols_reg  = DimReset;
  sum_t        col_best [MaxDim];
  sum_t        left_best = '0;
  int unsigned cur_row   = 0;
  int unsigned cur_col   = 0;
  sum_t        pending_sums [$];

  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  bit          src_idle_on   = 1'b1;
  bit          snk_idle_on   = 1'b1;
  int unsigned sink_hold_req = 0;

  function automatic int unsigned grid_span(cfg_t v);
    if (v == '0) return 1;
    if (int'(v) > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  function automatic int unsigned grid_cells();
    return grid_span(rows_reg) * grid_span(cols_reg);
  endfunction

  function automatic sum_t sat_sum(sum_t a, cost_t b);
    int unsigned s;
    s = 32'(a) + 32'(b);
    return (s > 32'(SumMax)) ? SumMax : sum_t'(s);
  endfunction

  // one DP step per accepted cell; queues the sum when the grid closes
  function automatic void update_path_costs(cost_t cost);
    int unsigned nr;
    int unsigned nc;
    sum_t        best;
    nr = grid_span(rows_reg);
    nc = grid_span(cols_reg);
    if (cur_row >= nr || cur_col >= nc) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_row == 0 && cur_col == 0) begin
      best = sum_t'(cost);
    end else if (cur_row == 0) begin
      best = sat_sum(left_best, cost);
    end else if (cur_col == 0) begin
      best = sat_sum(col_best[cur_col], cost);
    end else begin
      best = sat_sum((col_best[cur_col] < left_best) ? col_best[cur_col] : left_best, cost);
    end
    col_best[cur_col] = best;
    left_best         = best;
    if (cur_row == nr - 1 && cur_col == nc - 1) begin
      pending_sums.push_back(best);
      cur_row = 0;
      cur_col = 0;
    end else if (cur_col == nc - 1) begin
      cur_col = 0;
      cur_row++;
    end else begin
      cur_col++;
    end
  endfunction

  function automatic cost_t draw_cost(cost_mode_e mode);
    case (mode)
      CostMax:  return '1;
      CostZero: return '0;
      CostTie:  return cost_t'($urandom_range(0, 1));
      CostLow:  return cost_t'($urandom_range(0, 15));
      default:  return cost_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return CfgW'($urandom_range(1, 6));
    if (r == 7) return '0;
    if (r == 8) return CfgW'($urandom_range(7, 16));
    return CfgW'($urandom_range(65, 127));
  endfunction

  // valid stays high after a transfer unless a gap is taken
  task automatic send_cell(cost_t cost);
    cell_if.valid     <= 1'b1;
    cell_if.cell_cost <= cost;
    do begin
      @(posedge clk_i);
    end while (cell_if.ready !== 1'b1);
    update_path_costs(cost);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      cell_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_cells(int unsigned n, cost_mode_e mode);
    repeat (n) send_cell(draw_cost(mode));
  endtask

  task automatic wait_sums_drained();
    cell_if.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, cfg_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRows: begin
        rows_reg = value;
        cur_row  = 0;
        cur_col  = 0;
      end
      RegCols: begin
        cols_reg = value;
        cur_row  = 0;
        cur_col  = 0;
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_dims(cfg_t rows, cfg_t cols);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(RegRows, rows);
      write_reg(RegCols, cols);
    end else begin
      write_reg(RegCols, cols);
      write_reg(RegRows, rows);
    end
  endtask

  task automatic test_reset_dims();
    send_cells(grid_cells(), CostAny);
    send_cells(grid_cells(), CostLow);
  endtask

  task automatic test_directed_cases();
    wait_sums_drained();
    // zero dimensions act as one: each cell is a grid of its own
    write_reg(RegRows, '0);
    write_reg(RegCols, '0);
    send_cell('0);
    send_cell('1);
    wait_sums_drained();
    // spare index mid-grid is ignored and the grid carries on
    set_dims(CfgW'(2), CfgW'(2));
    send_cell('1);
    wait_sums_drained();
    write_reg(RegSpareLo, '1);
    send_cell(cost_t'(1));
    send_cell(cost_t'(2));
    send_cell('1);
    wait_sums_drained();
    write_reg(RegSpareHi, '0);
    // real write mid-grid restarts it
    send_cell(cost_t'(7));
    send_cell(cost_t'(9));
    wait_sums_drained();
    write_reg(RegCols, CfgW'(3));
    // second row: left wins over up in each column after the first
    send_cell(cost_t'(1));
    send_cell(cost_t'(200));
    send_cell(cost_t'(1));
    send_cell(cost_t'(3));
    send_cell(cost_t'(4));
    send_cell(cost_t'(0));
  endtask

  task automatic test_clamped_dims();
    cfg_t       rows_list [5] = '{CfgW'(1), CfgW'(64), CfgW'(65), CfgW'(3), CfgW'(127)};
    cfg_t       cols_list [5] = '{CfgW'(64), CfgW'(1), CfgW'(3), CfgW'(127), CfgW'(0)};
    cost_mode_e mode_list [5] = '{CostAny, CostLow, CostMax, CostMax, CostTie};
    foreach (rows_list[i]) begin
      wait_sums_drained();
      set_dims(rows_list[i], cols_list[i]);
      send_cells(grid_cells(), mode_list[i]);
    end
  endtask

  task automatic test_backpressure();
    wait_sums_drained();
    src_idle_on = 1'b0;
    set_dims(CfgW'(1), '0);
    sink_hold_req = 300;
    send_cells(40, CostAny);
    // sender holds back until every sum is out
    wait_sums_drained();
    send_cells(30, CostAny);
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_grids();
    int unsigned sent;
    int unsigned cells;
    int unsigned k;
    cfg_t        rv;
    cfg_t        cv;
    cost_mode_e  mode;
    sent = 0;
    while (sent < RandomCells) begin
      wait_sums_drained();
      rv = pick_dim();
      cv = pick_dim();
      if (grid_span(rv) * grid_span(cv) > 256) cv = CfgW'($urandom_range(0, 2));
      set_dims(rv, cv);
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      cells = grid_cells();
      repeat ($urandom_range(1, 6)) begin
        mode = cost_mode_e'($urandom_range(0, 4));
        if (cells > 1 && $urandom_range(0, 7) == 0) begin
          k = $urandom_range(1, cells - 1);
          send_cells(k, mode);
          wait_sums_drained();
          if ($urandom_range(0, 1) == 0) begin
            write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, cfg_t'($urandom));
          end
          send_cells(cells - k, mode);
        end else begin
          send_cells(cells, mode);
        end
        sent += cells;
      end
      // broken grid, cut short by the next register write
      if (cells > 1 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, cells - 1);
        send_cells(k, CostAny);
        sent += k;
      end
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    wait_sums_drained();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_dims(CfgW'(4), CfgW'(6));
    repeat (8) send_cells(grid_cells(), cost_mode_e'($urandom_range(0, 4)));
  endtask

  initial begin : sum_receiver
    sum_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold_req != 0) begin
        sum_if.ready <= 1'b0;
        repeat (sink_hold_req) @(posedge clk_i);
        sink_hold_req = 0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        sum_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        sum_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : sum_checker
    sum_t want;
    if (rst_ni && sum_if.valid === 1'b1 && sum_if.ready === 1'b1) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected min_sum, expected none, actual %0d",
                 $time, sum_if.min_sum);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        if (sum_if.min_sum !== want) begin
          $display("%0t: min_sum mismatch, expected %0d, actual %0d",
                   $time, want, sum_if.min_sum);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  initial begin : run_tests
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= RegRows;
    cfg_data_i        <= '0;
    cell_if.valid     <= 1'b0;
    cell_if.cell_cost <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_dims();
    test_directed_cases();
    test_clamped_dims();
    test_backpressure();
    test_random_grids();
    test_steady_stream();
    wait_sums_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
